/* rtl/rbt_pkg.sv */
// Shared constants, a result type and a function for the relay bank timer.
`timescale 1ns / 1ps
package rbt_pkg;

    localparam int NUM_RELAYS = 8;
    localparam int TIME_BITS = 16;
    localparam int TW = (TIME_BITS < 16) ? TIME_BITS : 16;
    localparam int IW = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;
    localparam logic [15:0] TIME_MAX = 16'((32'd1 << TW) - 32'd1);

    localparam logic [3:0] OP_ON = 4'd0;
    localparam logic [3:0] OP_ON_PERM = 4'd1;
    localparam logic [3:0] OP_OFF = 4'd2;
    localparam logic [3:0] OP_TOGGLE = 4'd3;
    localparam logic [3:0] OP_PUMP = 4'd4;
    localparam logic [3:0] OP_LIGHT = 4'd5;
    localparam logic [3:0] OP_NUTRIENT = 4'd6;
    localparam logic [3:0] OP_VENT = 4'd7;
    localparam logic [3:0] OP_STATUS = 4'd8;
    localparam logic [3:0] OP_TICK = 4'd9;

    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
    localparam logic [1:0] STAT_BAD_OPCODE = 2'd2;

    typedef struct packed {
        logic [TW-1:0] clamped;
        logic          le_one;
        logic [TW-1:0] dec;
    } rbt_time_res_t;

    function automatic logic [15:0] preset_secs(input logic [3:0] op);
        logic [15:0] secs;
        case (op)
            OP_PUMP:     secs = 16'd300;
            OP_LIGHT:    secs = 16'd57600;
            OP_NUTRIENT: secs = 16'd120;
            OP_VENT:     secs = 16'd900;
            default:     secs = 16'd0;
        endcase
        return secs;
    endfunction

endpackage

/* rtl/rbt_time_unit.sv */
// Shared time unit: clamps a duration and tests and decrements a running timer.
`timescale 1ns / 1ps
module rbt_time_unit
    import rbt_pkg::*;
(
    input  logic [15:0]   value,
    input  logic [15:0]   limit,
    output rbt_time_res_t res
);

    logic [15:0] lim_min;
    logic [15:0] val_min;

    always_comb begin
        lim_min = (limit < TIME_MAX) ? limit : TIME_MAX;
        val_min = (value < lim_min) ? value : lim_min;
        res.clamped = TW'(val_min);
        res.le_one = (value <= 16'd1);
        res.dec = TW'(value - 16'd1);
    end

endmodule

/* rtl/relay_bank_timer.sv */
// Relay bank with per-relay auto-off timers, sequenced over one shared time unit.
// A command word passes through ST_CMD, then ST_DONE raises m_tvalid; a tick word walks
// every relay timer, one per cycle, in ST_TICK, then ST_DONE raises m_tvalid.
// One word is in work at a time: a new word is taken only in ST_IDLE, and the result
// register lets it enter while the last result waits. Synchronous reset turns all relays
// off, stops all timers, max 65535.
`timescale 1ns / 1ps
module relay_bank_timer
    import rbt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[3:0], relay_index[7:4], duration_seconds[23:8]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], relay_on[2], remaining_seconds[18:3], drive_pattern[26:19],
    // expired_mask[34:27], zero fill above
    output logic [39:0] m_tdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_CMD, ST_TICK, ST_DONE} state_t;

    state_t                state_reg;
    logic [15:0]           max_dur_reg;
    logic [3:0]            op_reg;
    logic [3:0]            idx_reg;
    logic [15:0]           dur_reg;
    logic [IW-1:0]         cnt_reg;
    logic [NUM_RELAYS-1:0] on_reg;
    logic [NUM_RELAYS-1:0] act_reg;
    logic [TW-1:0]         tl_reg [NUM_RELAYS];
    logic [NUM_RELAYS-1:0] exp_reg;
    logic [1:0]            res_stat_reg;
    logic                  res_on_reg;
    logic [15:0]           res_rem_reg;
    logic                  m_tvalid_reg;
    logic [39:0]           m_tdata_reg;

    logic [IW-1:0]         rd_idx;
    logic [TW-1:0]         tl_rd;
    logic [15:0]           secs;
    logic [15:0]           unit_val;
    rbt_time_res_t         unit_res;
    logic                  idx_bad;
    logic                  nx_on;
    logic                  nx_act;
    logic [TW-1:0]         nx_tl;
    logic [1:0]            nx_stat;
    logic                  cur_on;
    logic [7:0]            drive;

    assign cfg_ready = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    assign rd_idx = (state_reg == ST_TICK) ? cnt_reg : idx_reg[IW-1:0];
    assign tl_rd = tl_reg[rd_idx];
    assign secs = (op_reg == OP_ON) ? dur_reg : preset_secs(op_reg);
    assign unit_val = (state_reg == ST_TICK) ? 16'(tl_rd) : secs;
    assign idx_bad = (idx_reg >= 4'(NUM_RELAYS));
    assign cur_on = on_reg[rd_idx];
    assign drive = ~(8'(on_reg));

    rbt_time_unit u_time (
        .value (unit_val),
        .limit (max_dur_reg),
        .res   (unit_res)
    );

    always_comb begin
        nx_on = cur_on;
        nx_act = act_reg[rd_idx];
        nx_tl = tl_rd;
        nx_stat = STAT_OK;
        case (op_reg)
            OP_ON, OP_PUMP, OP_LIGHT, OP_NUTRIENT, OP_VENT: begin
                nx_on = 1'b1;
                nx_act = (secs != 16'd0);
                nx_tl = (secs != 16'd0) ? unit_res.clamped : '0;
            end
            OP_ON_PERM: begin
                nx_on = 1'b1;
                nx_act = 1'b0;
                nx_tl = '0;
            end
            OP_OFF: begin
                nx_on = 1'b0;
                nx_act = 1'b0;
                nx_tl = '0;
            end
            OP_TOGGLE: begin
                nx_on = ~cur_on;
                nx_act = 1'b0;
                nx_tl = '0;
            end
            OP_STATUS: begin
                nx_stat = STAT_OK;
            end
            default: begin
                nx_stat = STAT_BAD_OPCODE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            max_dur_reg <= 16'hFFFF;
            on_reg <= '0;
            act_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                max_dur_reg <= cfg_data;
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg <= s_tdata[3:0];
                        idx_reg <= s_tdata[7:4];
                        dur_reg <= s_tdata[23:8];
                        cnt_reg <= '0;
                        exp_reg <= '0;
                        state_reg <= (s_tdata[3:0] == OP_TICK) ? ST_TICK : ST_CMD;
                    end
                end
                ST_CMD: begin
                    if (idx_bad) begin
                        res_stat_reg <= STAT_BAD_INDEX;
                        res_on_reg <= 1'b0;
                        res_rem_reg <= 16'd0;
                    end else begin
                        on_reg[rd_idx] <= nx_on;
                        act_reg[rd_idx] <= nx_act;
                        tl_reg[rd_idx] <= nx_tl;
                        res_stat_reg <= nx_stat;
                        res_on_reg <= nx_on;
                        res_rem_reg <= nx_act ? 16'(nx_tl) : 16'd0;
                    end
                    state_reg <= ST_DONE;
                end
                ST_TICK: begin
                    if (act_reg[rd_idx] && cur_on) begin
                        if (unit_res.le_one) begin
                            on_reg[rd_idx] <= 1'b0;
                            act_reg[rd_idx] <= 1'b0;
                            tl_reg[rd_idx] <= '0;
                            exp_reg[rd_idx] <= 1'b1;
                        end else begin
                            tl_reg[rd_idx] <= unit_res.dec;
                        end
                    end
                    res_stat_reg <= STAT_OK;
                    res_on_reg <= 1'b0;
                    res_rem_reg <= 16'd0;
                    if (cnt_reg == IW'(NUM_RELAYS - 1)) begin
                        state_reg <= ST_DONE;
                    end else begin
                        cnt_reg <= cnt_reg + IW'(1);
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg <= {5'd0, 8'(exp_reg), drive, res_rem_reg,
                                        res_on_reg, res_stat_reg};
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* verif/tb_relay_bank_timer.sv */
// Self-checking testbench for the relay bank timer, with a built-in predictor of the bank.
`timescale 1ns / 1ps
module tb_relay_bank_timer;
    import rbt_pkg::*;

    localparam logic [3:0] OP_BAD_FIRST = OP_TICK + 4'd1;
    localparam logic [3:0] OP_BAD_LAST = 4'hF;
    localparam int PHASE_ITEMS = 270;
    localparam int PHASES = 7;

    typedef struct packed {
        logic [4:0]  fill;
        logic [7:0]  expired;
        logic [7:0]  drive;
        logic [15:0] remaining;
        logic        on;
        logic [1:0]  status;
    } bank_report_t;

    typedef struct packed {
        logic [3:0]   op;
        logic [3:0]   idx;
        logic [15:0]  dur;
        logic         typed;
        bank_report_t want;
    } plan_row_t;

    localparam bank_report_t ALL_OFF = '{5'd0, 8'h00, 8'hFF, 16'd0, 1'b0, STAT_OK};

    localparam plan_row_t PLAN [22] = '{
        '{OP_STATUS,    4'd0,  16'd0,     1'b1, ALL_OFF},
        '{OP_TICK,      4'd0,  16'd0,     1'b1, ALL_OFF},
        '{OP_ON,        4'd0,  16'hFFFF,  1'b1, '{5'd0, 8'h00, 8'hFE, 16'hFFFF, 1'b1, STAT_OK}},
        '{OP_ON,        4'd7,  16'd0,     1'b1, '{5'd0, 8'h00, 8'h7E, 16'd0, 1'b1, STAT_OK}},
        '{OP_ON_PERM,   4'd3,  16'd0,     1'b0, '0},
        '{OP_TOGGLE,    4'd3,  16'd0,     1'b0, '0},
        '{OP_TOGGLE,    4'd3,  16'd0,     1'b0, '0},
        '{OP_OFF,       4'd7,  16'd0,     1'b0, '0},
        '{OP_PUMP,      4'd1,  16'd0,     1'b0, '0},
        '{OP_LIGHT,     4'd2,  16'd0,     1'b0, '0},
        '{OP_NUTRIENT,  4'd4,  16'd0,     1'b0, '0},
        '{OP_VENT,      4'd5,  16'd0,     1'b0, '0},
        '{OP_ON,        4'd6,  16'd1,     1'b0, '0},
        '{OP_TICK,      4'd0,  16'd0,     1'b0, '0},
        '{OP_STATUS,    4'd6,  16'd0,     1'b0, '0},
        '{OP_STATUS,    4'd8,  16'd0,     1'b0, '0},
        '{OP_BAD_LAST,  4'hF,  16'hFFFF,  1'b0, '0},
        '{OP_BAD_FIRST, 4'd0,  16'd0,     1'b0, '0},
        '{OP_TICK,      4'hF,  16'hFFFF,  1'b0, '0},
        '{OP_ON,        4'd2,  16'hAAAA,  1'b0, '0},
        '{OP_TOGGLE,    4'd0,  16'h5555,  1'b0, '0},
        '{OP_OFF,       4'd4,  16'hFFFF,  1'b0, '0}
    };

    localparam logic [15:0] MAX_STEPS [PHASES] = '{
        16'hFFFF, 16'd1, 16'd0, 16'd6, 16'h5A3C, 16'd300, 16'hFFFF
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    // Predicted bank state.
    bit          energized [NUM_RELAYS] = '{default: 1'b0};
    bit          armed [NUM_RELAYS] = '{default: 1'b0};
    logic [15:0] secs_left [NUM_RELAYS] = '{default: 16'd0};
    logic [15:0] max_secs = 16'hFFFF;

    bank_report_t reports_due [$];
    int           mismatches = 0;
    bit           quiet = 1'b0;
    int           hold_cnt = 0;

    relay_bank_timer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(99, 0);
        if (r < 50) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    function automatic void switch_plain(input int r, input bit on);
        armed[r] = 1'b0;
        secs_left[r] = '0;
        energized[r] = on;
    endfunction

    function automatic void switch_timed(input int r, input logic [15:0] secs);
        if (secs == 16'd0) begin
            switch_plain(r, 1'b1);
        end else begin
            energized[r] = 1'b1;
            armed[r] = 1'b1;
            secs_left[r] = (secs > max_secs) ? max_secs : secs;
        end
    endfunction

    function automatic bank_report_t next_bank_report(input logic [3:0] op,
                                                      input logic [3:0] idx,
                                                      input logic [15:0] dur);
        bank_report_t res;
        res = '0;
        if (op == OP_TICK) begin
            for (int i = 0; i < NUM_RELAYS; i++) begin
                if (armed[i] && energized[i]) begin
                    if (secs_left[i] <= 16'd1) begin
                        switch_plain(i, 1'b0);
                        res.expired[i] = 1'b1;
                    end else begin
                        secs_left[i] = secs_left[i] - 16'd1;
                    end
                end
            end
        end else if (idx >= NUM_RELAYS) begin
            res.status = STAT_BAD_INDEX;
        end else begin
            case (op)
                OP_ON:       switch_timed(idx, dur);
                OP_ON_PERM:  switch_plain(idx, 1'b1);
                OP_OFF:      switch_plain(idx, 1'b0);
                OP_TOGGLE:   switch_plain(idx, !energized[idx]);
                OP_PUMP:     switch_timed(idx, 16'd300);
                OP_LIGHT:    switch_timed(idx, 16'd57600);
                OP_NUTRIENT: switch_timed(idx, 16'd120);
                OP_VENT:     switch_timed(idx, 16'd900);
                OP_STATUS:   ;
                default:     res.status = STAT_BAD_OPCODE;
            endcase
            res.on = energized[idx];
            res.remaining = armed[idx] ? secs_left[idx] : 16'd0;
        end
        res.drive = 8'hFF;
        for (int i = 0; i < NUM_RELAYS; i++) begin
            if (energized[i]) begin
                res.drive[i] = 1'b0;
            end
        end
        return res;
    endfunction

    task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
        mismatches++;
        if (mismatches <= 50) begin
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        end
    endtask

    task automatic check_word(input bank_report_t got);
        bank_report_t want;
        if (reports_due.size() == 0) begin
            report("word with nothing due", got, '0);
            return;
        end
        want = reports_due.pop_front();
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.on !== want.on) report("relay_on", got.on, want.on);
        if (got.remaining !== want.remaining) report("remaining", got.remaining, want.remaining);
        if (got.drive !== want.drive) report("drive_pattern", got.drive, want.drive);
        if (got.expired !== want.expired) report("expired_mask", got.expired, want.expired);
        if (got.fill !== want.fill) report("zero fill", got.fill, want.fill);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_word(bank_report_t'(m_tdata));
        end
        if (hold_cnt != 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(2, 0) == 0) begin
                hold_cnt = pick_gap();
            end
        end
    end

    task automatic send_word(input logic [3:0] op, input logic [3:0] idx,
                             input logic [15:0] dur, input bit typed,
                             input bank_report_t typed_want);
        int gap;
        bank_report_t want;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {dur, idx, op};
        do @(posedge aclk); while (!s_tready);
        want = next_bank_report(op, idx, dur);
        reports_due.push_back(typed ? typed_want : want);
    endtask

    task automatic write_max(input logic [15:0] val);
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (NUM_RELAYS + 2) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_secs = val;
    endtask

    initial begin
        logic [3:0]  op;
        logic [3:0]  idx;
        logic [15:0] dur;
        int          r;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (PLAN[i]) begin
            send_word(PLAN[i].op, PLAN[i].idx, PLAN[i].dur, PLAN[i].typed, PLAN[i].want);
        end
        for (int p = 0; p < PHASES; p++) begin
            write_max(MAX_STEPS[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(49, 0) == 0) begin
                    quiet = !quiet;
                end
                r = $urandom_range(99, 0);
                if (r < 30) begin
                    op = OP_TICK;
                end else if (r < 50) begin
                    op = OP_ON;
                end else if (r < 92) begin
                    op = 4'($urandom_range(OP_STATUS, OP_ON_PERM));
                end else begin
                    op = 4'($urandom_range(OP_BAD_LAST, OP_BAD_FIRST));
                end
                if ($urandom_range(9, 0) != 0) begin
                    idx = 4'($urandom_range(NUM_RELAYS - 1, 0));
                end else begin
                    idx = 4'($urandom_range(15, NUM_RELAYS));
                end
                r = $urandom_range(99, 0);
                if (r < 60) begin
                    dur = 16'($urandom_range(8, 0));
                end else if (r < 85) begin
                    dur = 16'($urandom_range(400, 0));
                end else begin
                    dur = 16'($urandom);
                end
                send_word(op, idx, dur, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (4 * NUM_RELAYS) @(posedge aclk);
        if (mismatches == 0 && reports_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
